// ----- sv/fpcp_pkg.sv -----
package fpcp_pkg;

    // Field and register widths.
    localparam int C_COORD_BITS = 8;
    localparam int C_DIST_BITS  = 2 * C_COORD_BITS + 1;
    localparam int C_GRID_BITS  = 9;
    localparam int C_BORDER_BITS = 8;
    localparam int C_NUMC_BITS  = 5;
    localparam int C_SEED_BITS  = 16;
    localparam int C_CFG_IDX_BITS = 2;
    localparam int C_CFG_DATA_BITS = 9;

    // Default sizes for the top level.
    localparam int C_MAX_POINTS  = 4096;
    localparam int C_MAX_CENTERS = 16;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_BORDER      = 2'd2;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_NUM_CENTERS = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MOD,
        ST_RD_FIRST,
        ST_GET_FIRST,
        ST_EMIT,
        ST_PASS
    } t_state;

endpackage

// ----- sv/fpcp_tile_if.sv -----
interface fpcp_tile_if;
    logic       valid;
    logic       ready;
    logic [7:0] tile_x;
    logic [7:0] tile_y;
    logic       tile_empty;
    logic       last_tile;
    logic [15:0] seed;

    modport source (output valid, tile_x, tile_y, tile_empty, last_tile, seed, input ready);
    modport sink (input valid, tile_x, tile_y, tile_empty, last_tile, seed, output ready);
endinterface

// ----- sv/fpcp_center_if.sv -----
interface fpcp_center_if;
    logic       valid;
    logic       ready;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic       found;
    logic       last_center;

    modport source (output valid, center_x, center_y, found, last_center, input ready);
    modport sink (input valid, center_x, center_y, found, last_center, output ready);
endinterface

// ----- sv/fpcp_mem.sv -----
module fpcp_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/fpcp_mod.sv -----
module fpcp_mod #(
    parameter int CW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_rem
);
    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [15:0]   r_dvd;
    logic [CW-1:0] r_div;
    logic [CW-1:0] r_rem;
    logic          r_done;
    logic [CW:0]   w_trial;
    logic [CW:0]   w_diff;
    logic [CW-1:0] n_rem;

    // Restoring remainder, one dividend bit per cycle.
    always_comb begin
        w_trial = {r_rem, r_dvd[15]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[CW-1:0];
        end else begin
            n_rem = w_trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ----- sv/farthest_point_center_picker_top.sv -----
// Tiles are taken one per cycle while the block is loading candidates.
// After the last tile the divider reduces the seed modulo the candidate count, the first
// center is fetched and loaded, and each further center then takes a full candidate pass.
// Each center waits in an output register until taken; one transaction at a time.
// Synchronous active-low reset restores register defaults and empties the run;
// the candidate memories are not cleared, only entries below the count are read.
module farthest_point_center_picker_top #(
    parameter int MAX_POINTS = fpcp_pkg::C_MAX_POINTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fpcp_tile_if.sink     i_tile,
    fpcp_center_if.source o_center,
    input  logic                                   i_cfg_we,
    input  logic [fpcp_pkg::C_CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [fpcp_pkg::C_CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import fpcp_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = (CW > C_NUMC_BITS) ? CW : C_NUMC_BITS;
    localparam int XW = C_COORD_BITS;
    localparam int DW = C_DIST_BITS;

    // Configuration registers.
    logic [C_GRID_BITS-1:0]   r_grid_w;
    logic [C_GRID_BITS-1:0]   r_grid_h;
    logic [C_BORDER_BITS-1:0] r_border;
    logic [C_NUMC_BITS-1:0]   r_num_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= 9'd256;
            r_grid_h <= 9'd256;
            r_border <= 8'd0;
            r_num_c  <= 5'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_w <= i_cfg_wdata;
                CFG_GRID_HEIGHT: r_grid_h <= i_cfg_wdata;
                CFG_BORDER:      r_border <= i_cfg_wdata[C_BORDER_BITS-1:0];
                CFG_NUM_CENTERS: r_num_c  <= i_cfg_wdata[C_NUMC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Run state.
    t_state r_state, n_state;
    logic [CW-1:0]          r_count;
    logic [C_NUMC_BITS-1:0] r_chosen;
    logic                   r_none;
    logic                   r_first;
    logic [AW-1:0]          r_cidx;
    logic [XW-1:0]          r_cx, r_cy;

    // Pass pipeline.
    logic [CW-1:0] r_iss;
    logic          r_s1_v;
    logic [AW-1:0] r_s1_idx;
    logic          r_s2_v;
    logic [AW-1:0] r_s2_idx;
    logic [2*XW-1:0] r_s2_sqx, r_s2_sqy;
    logic [DW:0]   r_s2_old;
    logic          r_s2_hit;
    logic [XW-1:0] r_s2_x, r_s2_y;
    logic          r_have;
    logic [DW-1:0] r_best_d;
    logic [AW-1:0] r_best_idx;
    logic [XW-1:0] r_best_x, r_best_y;

    // Output register.
    logic          r_out_v;
    logic [XW-1:0] r_out_x, r_out_y;
    logic          r_out_found, r_out_last;

    // Memory and divider hookup.
    logic            w_crd_we;
    logic [2*XW-1:0] w_crd_rdata;
    logic [AW-1:0]   w_raddr;
    logic            w_dst_we;
    logic [DW:0]     w_dst_wdata;
    logic [DW:0]     w_dst_rdata;
    logic            w_mod_start;
    logic            w_mod_done;
    logic [CW-1:0]   w_mod_rem;

    // Tile qualification.
    logic          w_in_acc;
    logic          w_qual;
    logic [CW-1:0] w_cnt_next;
    logic [C_NUMC_BITS-1:0] w_target;
    logic [C_NUMC_BITS-1:0] w_chosen_next;
    logic          w_emit_last;
    logic          w_pass_done;

    assign i_tile.ready = (r_state == ST_LOAD);
    assign w_in_acc = i_tile.valid && i_tile.ready;

    assign w_qual = i_tile.tile_empty
        && (i_tile.tile_x >= r_border)
        && (({2'b0, i_tile.tile_x} + {2'b0, r_border}) < {1'b0, r_grid_w})
        && (i_tile.tile_y >= r_border)
        && (({2'b0, i_tile.tile_y} + {2'b0, r_border}) < {1'b0, r_grid_h})
        && (r_count < CW'(MAX_POINTS));
    assign w_crd_we   = w_in_acc && w_qual;
    assign w_cnt_next = w_crd_we ? (r_count + CW'(1)) : r_count;
    assign w_mod_start = w_in_acc && i_tile.last_tile && (w_cnt_next != '0);

    // Target count clamped to one and to the maximum.
    always_comb begin
        if (r_num_c == '0) begin
            w_target = C_NUMC_BITS'(1);
        end else if (r_num_c > C_NUMC_BITS'(C_MAX_CENTERS)) begin
            w_target = C_NUMC_BITS'(C_MAX_CENTERS);
        end else begin
            w_target = r_num_c;
        end
    end

    assign w_chosen_next = r_chosen + C_NUMC_BITS'(1);
    assign w_emit_last = r_none || (w_chosen_next == w_target)
        || (KW'(w_chosen_next) == KW'(r_count));
    assign w_pass_done = (r_iss == r_count) && !r_s1_v && !r_s2_v;
    assign w_raddr = (r_state == ST_PASS) ? r_iss[AW-1:0] : r_cidx;

    fpcp_mem #(.DEPTH(MAX_POINTS), .WIDTH(2 * XW), .AW(AW)) u_crd_mem (
        .i_clk   (i_clk),
        .i_we    (w_crd_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_tile.tile_y, i_tile.tile_x}),
        .i_raddr (w_raddr),
        .o_rdata (w_crd_rdata)
    );

    fpcp_mem #(.DEPTH(MAX_POINTS), .WIDTH(DW + 1), .AW(AW)) u_dst_mem (
        .i_clk   (i_clk),
        .i_we    (w_dst_we),
        .i_waddr (r_s2_idx),
        .i_wdata (w_dst_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_dst_rdata)
    );

    fpcp_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_tile.seed),
        .i_divisor  (w_cnt_next),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Stage one: absolute differences and squares against the current center.
    logic [XW-1:0]   w_mx, w_my, w_dx, w_dy;
    logic [2*XW-1:0] w_sqx, w_sqy;
    always_comb begin
        w_mx = w_crd_rdata[XW-1:0];
        w_my = w_crd_rdata[2*XW-1:XW];
        w_dx = (r_cx > w_mx) ? (r_cx - w_mx) : (w_mx - r_cx);
        w_dy = (r_cy > w_my) ? (r_cy - w_my) : (w_my - r_cy);
        w_sqx = {{XW{1'b0}}, w_dx} * {{XW{1'b0}}, w_dx};
        w_sqy = {{XW{1'b0}}, w_dy} * {{XW{1'b0}}, w_dy};
    end

    // Stage two: new nearest distance, write-back and running farthest pick.
    logic [DW-1:0] w_d, w_new_d;
    logic          w_new_t;
    logic          w_better;
    always_comb begin
        w_d = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        if (r_first) begin
            w_new_t = r_s2_hit;
            w_new_d = w_d;
        end else begin
            w_new_t = r_s2_old[DW] | r_s2_hit;
            w_new_d = (w_d < r_s2_old[DW-1:0]) ? w_d : r_s2_old[DW-1:0];
        end
        w_better = r_s2_v && !w_new_t && (!r_have || (w_new_d > r_best_d));
    end
    assign w_dst_we    = r_s2_v;
    assign w_dst_wdata = {w_new_t, w_new_d};

    always_ff @(posedge i_clk) begin
        r_s2_sqx <= w_sqx;
        r_s2_sqy <= w_sqy;
        r_s2_old <= w_dst_rdata;
        r_s2_hit <= (r_s1_idx == r_cidx);
        r_s2_x   <= w_mx;
        r_s2_y   <= w_my;
        r_s2_idx <= r_s1_idx;
        r_s1_idx <= r_iss[AW-1:0];
        if (w_better) begin
            r_best_d   <= w_new_d;
            r_best_idx <= r_s2_idx;
            r_best_x   <= r_s2_x;
            r_best_y   <= r_s2_y;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_tile.last_tile) begin
                    n_state = (w_cnt_next == '0) ? ST_EMIT : ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_mod_done) begin
                    n_state = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST:  n_state = ST_GET_FIRST;
            ST_GET_FIRST: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_v) begin
                    n_state = w_emit_last ? ST_LOAD : ST_PASS;
                end
            end
            ST_PASS: begin
                if (w_pass_done) begin
                    n_state = ST_EMIT;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Control registers of the run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_chosen <= '0;
            r_none   <= 1'b0;
            r_first  <= 1'b0;
            r_iss    <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_have   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_PASS) && (r_iss != r_count);
            r_s2_v <= r_s1_v;
            if (r_state == ST_PASS && r_iss != r_count) begin
                r_iss <= r_iss + CW'(1);
            end
            if (w_better) begin
                r_have <= 1'b1;
            end
            if (o_center.valid && o_center.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    r_count <= w_cnt_next;
                    r_none  <= (w_cnt_next == '0);
                end
                ST_GET_FIRST: begin
                    r_first <= 1'b1;
                end
                ST_EMIT: begin
                    if (!r_out_v) begin
                        r_out_v <= 1'b1;
                        r_iss   <= '0;
                        r_have  <= 1'b0;
                        if (w_emit_last) begin
                            r_count  <= '0;
                            r_chosen <= '0;
                        end else begin
                            r_chosen <= w_chosen_next;
                        end
                    end
                end
                ST_PASS: begin
                    if (w_pass_done) begin
                        r_first <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Current center and output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (r_state == ST_MOD) begin
            r_cidx <= w_mod_rem[AW-1:0];
        end else if (r_state == ST_GET_FIRST) begin
            r_cx <= w_crd_rdata[XW-1:0];
            r_cy <= w_crd_rdata[2*XW-1:XW];
        end else if (r_state == ST_PASS && w_pass_done) begin
            r_cx   <= r_best_x;
            r_cy   <= r_best_y;
            r_cidx <= r_best_idx;
        end
        if (r_state == ST_EMIT && !r_out_v) begin
            r_out_x     <= r_cx;
            r_out_y     <= r_cy;
            r_out_found <= !r_none;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_center.valid       = r_out_v;
    assign o_center.center_x    = r_out_x;
    assign o_center.center_y    = r_out_y;
    assign o_center.found       = r_out_found;
    assign o_center.last_center = r_out_last;

`ifndef ASSERT_OFF
    // A result without a center always ends the run.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_found) |-> r_out_last)
        else $error("no-candidate result not marked last");

    // The number of chosen centers never passes the clamped target.
    a_chosen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chosen <= w_target)
        else $error("chosen count above target");

    // Every write-back in a pass lands inside the candidate list.
    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dst_we |-> (CW'(r_s2_idx) < r_count))
        else $error("distance write beyond candidate count");

    // The seed remainder picks an existing candidate.
    a_first_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (w_mod_rem < r_count))
        else $error("first center index out of range");
`endif
endmodule
